// ===== rtl/arlk_pkg.sv =====
// shared constants, types and rounding helper for the ankle rod length unit
package arlk_pkg;

    localparam int ANG_W    = 15;
    localparam int LEN_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROD_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROD_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROD_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Z = 3'd6;

    // reset values
    localparam logic signed [CFG_W-1:0] RST_ROD_X    = -16'sd2240;
    localparam logic signed [CFG_W-1:0] RST_ROD_Y    = 16'sd1408;
    localparam logic signed [CFG_W-1:0] RST_ROD_Z    = 16'sd2144;
    localparam logic signed [CFG_W-1:0] RST_AXIS_Z   = -16'sd2144;
    localparam logic signed [CFG_W-1:0] RST_ANCHOR_X = 16'sd1654;
    localparam logic signed [CFG_W-1:0] RST_ANCHOR_Y = 16'sd2240;
    localparam logic signed [CFG_W-1:0] RST_ANCHOR_Z = 16'sd20213;

    // angle reduction, 1/128 degree
    localparam logic [15:0] QUARTER    = 16'd11520;
    localparam logic [15:0] EIGHTH     = 16'd5760;
    localparam logic [15:0] HALF_TURN  = 16'd23040;
    localparam logic [15:0] THREE_QUARTER = 16'd34560;
    localparam logic signed [16:0] FULL_TURN = 17'sd46080;

    // q30 unity and degree step to radians, scaled by 2^10
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [27:0] RAD_K   = 28'd149922641;

    // taylor series divisors, innermost first
    localparam int SIN_TERMS = 5;
    localparam int COS_TERMS = 6;
    localparam int SIN_DIV [0:SIN_TERMS-1] = '{110, 72, 42, 20, 6};
    localparam int COS_DIV [0:COS_TERMS-1] = '{132, 90, 56, 30, 12, 2};

    // pipeline depths
    localparam int SIDE_DEPTH = 2 * COS_TERMS + 1;
    localparam int TRIG_LAT   = 16;
    localparam int SUM_W      = 62;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int ROD_LAT    = 10 + SQRT_STEPS;
    localparam int PIPE_LAT   = TRIG_LAT + ROD_LAT;

    typedef struct packed {
        logic signed [31:0] sin_v;
        logic signed [31:0] cos_v;
    } arlk_sincos_t;

    // shift right with rounding to nearest, ties away from zero
    function automatic logic signed [63:0] round_away(input logic signed [63:0] v,
                                                      input int unsigned sh);
        logic [63:0] mag;
        logic [63:0] rnd;
        mag = v[63] ? 64'(-v) : 64'(v);
        rnd = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(rnd) : $signed(rnd);
    endfunction

endpackage

// ===== rtl/arlk_horner_cell.sv =====
// one horner step of a taylor series: t_out = 1 - (x2 * t_in) / DIV, two stages
module arlk_horner_cell
    import arlk_pkg::*;
#(
    parameter int DIV = 6
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [29:0] x2,
    input  logic [30:0] t_in,
    output logic [30:0] t_out
);

    // exact floor division through a rounded-up reciprocal
    localparam int SH = 30 + $clog2(DIV);
    localparam logic [31:0] RECIP = 32'(((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV));

    logic [60:0] prod;
    logic [29:0] m_next;
    logic [29:0] m_reg;
    logic [61:0] qprod;
    logic [30:0] t_next;
    logic [30:0] t_reg;

    assign prod   = x2 * t_in;
    assign m_next = 30'((prod + 61'd536870912) >> 30);
    assign qprod  = m_reg * RECIP;
    assign t_next = Q30_ONE - 31'(qprod >> SH);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m_next;
            t_reg <= t_next;
        end
    end

    assign t_out = t_reg;

endmodule

// ===== rtl/arlk_trig.sv =====
// sine and cosine of an angle in 1/128 degree, q30 result
module arlk_trig
    import arlk_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] angle,
    output arlk_sincos_t            sc
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [29:0] x2;
        logic [29:0] x;
        logic [1:0]  quad;
        logic        swap;
    } side_t;

    logic signed [16:0] a_ext;
    logic [15:0]        u;
    logic [1:0]         quad_next;
    logic [13:0]        rem;
    logic [12:0]        r_next;
    logic               swap_next;

    logic [12:0] r_reg;
    logic [1:0]  quad_reg;
    logic        swap_reg;

    logic [40:0] xprod;
    logic [29:0] x_next;
    logic [29:0] x_reg;
    logic [1:0]  quad_b_reg;
    logic        swap_b_reg;

    logic [59:0] xsq;
    side_t       side_next;
    side_t       side_reg [0:SIDE_DEPTH-1];

    logic [30:0] sin_t [0:SIN_TERMS];
    logic [30:0] cos_t [0:COS_TERMS];

    logic [60:0] sprod;
    logic [29:0] sf_next;
    logic [29:0] sf_reg;
    logic [29:0] sf2_reg;

    logic signed [31:0] ss;
    logic signed [31:0] cc;
    arlk_sincos_t       sc_next;
    arlk_sincos_t       sc_reg;

    // quadrant and octant reduction
    always_comb
    begin
        a_ext = 17'(angle);
        u     = angle[ANG_W-1] ? 16'(a_ext + FULL_TURN) : 16'(a_ext);
        if (u >= THREE_QUARTER)
        begin
            quad_next = QUAD_3;
            rem       = 14'(u - THREE_QUARTER);
        end
        else if (u >= HALF_TURN)
        begin
            quad_next = QUAD_2;
            rem       = 14'(u - HALF_TURN);
        end
        else if (u >= QUARTER)
        begin
            quad_next = QUAD_1;
            rem       = 14'(u - QUARTER);
        end
        else
        begin
            quad_next = QUAD_0;
            rem       = 14'(u);
        end
        swap_next = (16'(rem) > EIGHTH);
        r_next    = swap_next ? 13'(QUARTER - 16'(rem)) : 13'(rem);
    end

    // radians in q30
    assign xprod  = r_reg * RAD_K;
    assign x_next = 30'((xprod + 41'd512) >> 10);

    // x squared in q30
    assign xsq = x_reg * x_reg;
    always_comb
    begin
        side_next.x2   = 30'((xsq + 60'd536870912) >> 30);
        side_next.x    = x_reg;
        side_next.quad = quad_b_reg;
        side_next.swap = swap_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg       <= r_next;
            quad_reg    <= quad_next;
            swap_reg    <= swap_next;
            x_reg       <= x_next;
            quad_b_reg  <= quad_reg;
            swap_b_reg  <= swap_reg;
            side_reg[0] <= side_next;
            for (int k = 1; k < SIDE_DEPTH; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign sin_t[0] = Q30_ONE;
    assign cos_t[0] = Q30_ONE;

    genvar gi;
    generate
        for (gi = 0; gi < SIN_TERMS; gi++)
        begin : g_sin
            arlk_horner_cell #(.DIV(SIN_DIV[gi])) u_cell (
                .clk   (clk),
                .en    (en),
                .x2    (side_reg[2*gi].x2),
                .t_in  (sin_t[gi]),
                .t_out (sin_t[gi+1])
            );
        end
        for (gi = 0; gi < COS_TERMS; gi++)
        begin : g_cos
            arlk_horner_cell #(.DIV(COS_DIV[gi])) u_cell (
                .clk   (clk),
                .en    (en),
                .x2    (side_reg[2*gi].x2),
                .t_in  (cos_t[gi]),
                .t_out (cos_t[gi+1])
            );
        end
    endgenerate

    // closing multiply of the sine, padded to match the cosine
    assign sprod   = side_reg[2*SIN_TERMS].x * sin_t[SIN_TERMS];
    assign sf_next = 30'((sprod + 61'd536870912) >> 30);

    // quadrant symmetry
    always_comb
    begin
        ss = side_reg[SIDE_DEPTH-1].swap ? 32'(cos_t[COS_TERMS]) : 32'(sf2_reg);
        cc = side_reg[SIDE_DEPTH-1].swap ? 32'(sf2_reg) : 32'(cos_t[COS_TERMS]);
        case (side_reg[SIDE_DEPTH-1].quad)
            QUAD_0:
            begin
                sc_next.sin_v = ss;
                sc_next.cos_v = cc;
            end
            QUAD_1:
            begin
                sc_next.sin_v = cc;
                sc_next.cos_v = -ss;
            end
            QUAD_2:
            begin
                sc_next.sin_v = -ss;
                sc_next.cos_v = -cc;
            end
            default:
            begin
                sc_next.sin_v = -cc;
                sc_next.cos_v = ss;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sf_reg  <= sf_next;
            sf2_reg <= sf_reg;
            sc_reg  <= sc_next;
        end
    end

    assign sc = sc_reg;

endmodule

// ===== rtl/arlk_sqrt_cell.sv =====
// one digit of a floor integer square root
module arlk_sqrt_cell
    import arlk_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [SUM_W-1:0] n_in,
    input  logic [SUM_W-1:0] r_in,
    output logic [SUM_W-1:0] n_out,
    output logic [SUM_W-1:0] r_out
);

    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * STEP);

    logic [SUM_W-1:0] trial;
    logic [SUM_W-1:0] n_next;
    logic [SUM_W-1:0] r_next;
    logic [SUM_W-1:0] n_reg;
    logic [SUM_W-1:0] r_reg;

    always_comb
    begin
        trial = r_in + BIT;
        if (n_in >= trial)
        begin
            n_next = n_in - trial;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            n_next = n_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_next;
            r_reg <= r_next;
        end
    end

    assign n_out = n_reg;
    assign r_out = r_reg;

endmodule

// ===== rtl/arlk_rod.sv =====
// joint position, distance to anchor and square root for one rod
module arlk_rod
    import arlk_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  arlk_sincos_t            pitch_sc,
    input  arlk_sincos_t            roll_sc,
    input  logic signed [16:0]      rod_y,
    input  logic signed [16:0]      anc_y,
    input  logic signed [CFG_W-1:0] rod_x,
    input  logic signed [CFG_W-1:0] rod_z,
    input  logic signed [CFG_W-1:0] axis_z,
    input  logic signed [CFG_W-1:0] anc_x,
    input  logic signed [CFG_W-1:0] anc_z,
    output logic [LEN_W-1:0]        rod_length
);

    // roll rotation
    logic signed [48:0] p_ycr_next, p_ysr_next, p_ycr_reg, p_ysr_reg;
    logic signed [47:0] p_zsr_next, p_zcr_next, p_zsr_reg, p_zcr_reg;
    logic signed [49:0] vy30_next, vy30_reg;
    logic signed [51:0] vz30_next, vz30_reg;
    logic signed [30:0] vy12_next, vz12_next, vy12_reg, vz12_reg;
    arlk_sincos_t       pitch_d1_reg, pitch_d2_reg, pitch_d3_reg;

    // pitch rotation
    logic signed [27:0] vx12;
    logic signed [59:0] q1_next, q4_next, q1_reg, q4_reg;
    logic signed [62:0] q2_next, q3_next, q2_reg, q3_reg;
    logic signed [63:0] cx_next, cz_next, cx_reg, cz_reg;
    logic signed [31:0] cx12_next, cz12_next, cx12_reg, cz12_reg;
    logic signed [30:0] vy12_d1_reg, vy12_d2_reg, vy12_d3_reg;

    // distance
    logic signed [27:0] ax12, az12;
    logic signed [28:0] ay12;
    logic signed [32:0] dx_full, dy_full, dz_full;
    logic [29:0]        dx_next, dy_next, dz_next, dx_reg, dy_reg, dz_reg;
    logic [59:0]        sx_next, sy_next, sz_next, sx_reg, sy_reg, sz_reg;
    logic [SUM_W-1:0]   sum_next, sum_reg;

    logic [SUM_W-1:0] n_w [0:SQRT_STEPS];
    logic [SUM_W-1:0] r_w [0:SQRT_STEPS];
    logic [SUM_W-1:0] len_full;
    logic [LEN_W-1:0] len_next, len_reg;

    assign p_ycr_next = rod_y * roll_sc.cos_v;
    assign p_ysr_next = rod_y * roll_sc.sin_v;
    assign p_zsr_next = rod_z * roll_sc.sin_v;
    assign p_zcr_next = rod_z * roll_sc.cos_v;

    assign vy30_next = p_ycr_reg - p_zsr_reg;
    assign vz30_next = p_ysr_reg + p_zcr_reg + (52'(axis_z) <<< 30);

    assign vy12_next = 31'(round_away(64'(vy30_reg), 18));
    assign vz12_next = 31'(round_away(64'(vz30_reg), 18));

    assign vx12    = {rod_x, 12'd0};
    assign q1_next = pitch_d3_reg.cos_v * vx12;
    assign q2_next = pitch_d3_reg.sin_v * vz12_reg;
    assign q3_next = pitch_d3_reg.cos_v * vz12_reg;
    assign q4_next = pitch_d3_reg.sin_v * vx12;

    assign cx_next = q1_reg + q2_reg;
    assign cz_next = q3_reg - q4_reg;

    assign cx12_next = 32'(round_away(cx_reg, 30));
    assign cz12_next = 32'(round_away(cz_reg, 30));

    assign ax12    = {anc_x, 12'd0};
    assign ay12    = {anc_y, 12'd0};
    assign az12    = {anc_z, 12'd0};
    assign dx_full = 33'(ax12) - 33'(cx12_reg);
    assign dy_full = 33'(ay12) - 33'(vy12_d3_reg);
    assign dz_full = 33'(az12) - 33'(cz12_reg);
    // magnitudes stay below 2^30 for any register setting
    assign dx_next = 30'(dx_full[32] ? -dx_full : dx_full);
    assign dy_next = 30'(dy_full[32] ? -dy_full : dy_full);
    assign dz_next = 30'(dz_full[32] ? -dz_full : dz_full);

    assign sx_next  = dx_reg * dx_reg;
    assign sy_next  = dy_reg * dy_reg;
    assign sz_next  = dz_reg * dz_reg;
    assign sum_next = SUM_W'(sx_reg) + SUM_W'(sy_reg) + SUM_W'(sz_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ycr_reg    <= p_ycr_next;
            p_ysr_reg    <= p_ysr_next;
            p_zsr_reg    <= p_zsr_next;
            p_zcr_reg    <= p_zcr_next;
            pitch_d1_reg <= pitch_sc;
            vy30_reg     <= vy30_next;
            vz30_reg     <= vz30_next;
            pitch_d2_reg <= pitch_d1_reg;
            vy12_reg     <= vy12_next;
            vz12_reg     <= vz12_next;
            pitch_d3_reg <= pitch_d2_reg;
            q1_reg       <= q1_next;
            q2_reg       <= q2_next;
            q3_reg       <= q3_next;
            q4_reg       <= q4_next;
            vy12_d1_reg  <= vy12_reg;
            cx_reg       <= cx_next;
            cz_reg       <= cz_next;
            vy12_d2_reg  <= vy12_d1_reg;
            cx12_reg     <= cx12_next;
            cz12_reg     <= cz12_next;
            vy12_d3_reg  <= vy12_d2_reg;
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            dz_reg       <= dz_next;
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            sz_reg       <= sz_next;
            sum_reg      <= sum_next;
            len_reg      <= len_next;
        end
    end

    // root digits, most significant first
    assign n_w[0] = sum_reg;
    assign r_w[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < SQRT_STEPS; gi++)
        begin : g_sqrt
            arlk_sqrt_cell #(.STEP(SQRT_STEPS - 1 - gi)) u_cell (
                .clk   (clk),
                .en    (en),
                .n_in  (n_w[gi]),
                .r_in  (r_w[gi]),
                .n_out (n_w[gi+1]),
                .r_out (r_w[gi+1])
            );
        end
    endgenerate

    // q12 root to 1/64 mm, saturated
    assign len_full = (r_w[SQRT_STEPS] + SUM_W'(2048)) >> 12;
    assign len_next = (|len_full[SUM_W-1:LEN_W]) ? {LEN_W{1'b1}} : len_full[LEN_W-1:0];

    assign rod_length = len_reg;

endmodule

// ===== rtl/ankle_rod_length_kinematics_unit.sv =====
// top level: rod lengths of a two-rod parallel ankle from pitch and roll
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in      | in        | in_valid, in_stall | pitch_angle, roll_angle (1/128 deg)
//  out     | out       | out_valid,out_stall| first_rod_length, second_rod_length
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
//  one item enters per cycle while the pipeline is not frozen; an accepted item
//  reaches the output register through the 16 stage sine/cosine cells and the 41 stage
//  rod path, of which 31 are square root digit cells
//  the whole pipeline advances together and freezes only while a finished item
//  sits in the output register and out_stall is high; in_stall follows that
//  reset clears the valid line and loads the register defaults, payload is not reset
module ankle_rod_length_kinematics_unit
    import arlk_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [ANG_W-1:0] pitch_angle,
    input  logic signed [ANG_W-1:0] roll_angle,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [LEN_W-1:0]        first_rod_length,
    output logic [LEN_W-1:0]        second_rod_length,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    // geometry registers
    logic signed [CFG_W-1:0] rod_x_reg, rod_y_reg, rod_z_reg, axis_z_reg;
    logic signed [CFG_W-1:0] anchor_x_reg, anchor_y_reg, anchor_z_reg;

    // one valid flag per pipeline stage
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;
    logic                en;

    arlk_sincos_t pitch_sc;
    arlk_sincos_t roll_sc;

    // mirrored y for the second rod, one extra bit so the most negative value negates
    logic signed [16:0] rod_y_pos, rod_y_neg, anc_y_pos, anc_y_neg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rod_x_reg    <= RST_ROD_X;
            rod_y_reg    <= RST_ROD_Y;
            rod_z_reg    <= RST_ROD_Z;
            axis_z_reg   <= RST_AXIS_Z;
            anchor_x_reg <= RST_ANCHOR_X;
            anchor_y_reg <= RST_ANCHOR_Y;
            anchor_z_reg <= RST_ANCHOR_Z;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROD_X:    rod_x_reg    <= cfg_data;
                REG_ROD_Y:    rod_y_reg    <= cfg_data;
                REG_ROD_Z:    rod_z_reg    <= cfg_data;
                REG_AXIS_Z:   axis_z_reg   <= cfg_data;
                REG_ANCHOR_X: anchor_x_reg <= cfg_data;
                REG_ANCHOR_Y: anchor_y_reg <= cfg_data;
                REG_ANCHOR_Z: anchor_z_reg <= cfg_data;
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // pipeline moves unless a finished item is held at the output
    assign en       = !(vld_reg[PIPE_LAT-1] && out_stall);
    assign in_stall = !en;
    assign vld_next = {vld_reg[PIPE_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign out_valid = vld_reg[PIPE_LAT-1];

    arlk_trig u_pitch (
        .clk   (clk),
        .en    (en),
        .angle (pitch_angle),
        .sc    (pitch_sc)
    );

    arlk_trig u_roll (
        .clk   (clk),
        .en    (en),
        .angle (roll_angle),
        .sc    (roll_sc)
    );

    assign rod_y_pos = 17'(rod_y_reg);
    assign rod_y_neg = -rod_y_pos;
    assign anc_y_pos = 17'(anchor_y_reg);
    assign anc_y_neg = -anc_y_pos;

    arlk_rod u_rod_first (
        .clk        (clk),
        .en         (en),
        .pitch_sc   (pitch_sc),
        .roll_sc    (roll_sc),
        .rod_y      (rod_y_pos),
        .anc_y      (anc_y_pos),
        .rod_x      (rod_x_reg),
        .rod_z      (rod_z_reg),
        .axis_z     (axis_z_reg),
        .anc_x      (anchor_x_reg),
        .anc_z      (anchor_z_reg),
        .rod_length (first_rod_length)
    );

    arlk_rod u_rod_second (
        .clk        (clk),
        .en         (en),
        .pitch_sc   (pitch_sc),
        .roll_sc    (roll_sc),
        .rod_y      (rod_y_neg),
        .anc_y      (anc_y_neg),
        .rod_x      (rod_x_reg),
        .rod_z      (rod_z_reg),
        .axis_z     (axis_z_reg),
        .anc_x      (anchor_x_reg),
        .anc_z      (anchor_z_reg),
        .rod_length (second_rod_length)
    );

    // a held result must freeze the input side
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("held result did not stall the input");

    // an accepted item occupies the first stage
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted item lost at pipeline entry");

    // a taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !vld_reg[PIPE_LAT-2] |=> !out_valid)
        else $error("result repeated after it was taken");

endmodule

// ===== bench/tb_ankle_rod_length_kinematics_unit.sv =====
// testbench for the ankle rod length unit: scoreboard with its own fixed-point predictor
class rod_length_scoreboard;
    // register copy, same order as the register indexes
    longint geom [0:6];
    logic [15:0] first_q[$];
    logic [15:0] second_q[$];
    int n_fail;
    int n_seen;

    function void load_defaults();
        geom[0] = -2240; geom[1] = 1408; geom[2] = 2144; geom[3] = -2144;
        geom[4] = 1654;  geom[5] = 2240; geom[6] = 20213;
    endfunction

    function void write_reg(int idx, logic [15:0] data);
        if (idx < 7)
            geom[idx] = longint'($signed(data));
    endfunction

    function longint round_half_away(longint v, int sh);
        longint half;
        half = longint'(1) << (sh - 1);
        if (v < 0)
            return -((-v + half) >>> sh);
        return (v + half) >>> sh;
    endfunction

    function longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // sine and cosine over [0, 45] degrees, q30
    function void octant(longint unsigned r, output longint unsigned s,
                         output longint unsigned c);
        longint unsigned one, x, x2, t;
        one = 64'd1 << 30;
        x = (r * 64'd149922641 + 64'd512) >> 10;
        x2 = q30_mul(x, x);
        t = one - x2 / 110;
        t = one - q30_mul(x2, t) / 72;
        t = one - q30_mul(x2, t) / 42;
        t = one - q30_mul(x2, t) / 20;
        t = one - q30_mul(x2, t) / 6;
        s = q30_mul(x, t);
        t = one - x2 / 132;
        t = one - q30_mul(x2, t) / 90;
        t = one - q30_mul(x2, t) / 56;
        t = one - q30_mul(x2, t) / 30;
        t = one - q30_mul(x2, t) / 12;
        c = one - q30_mul(x2, t) / 2;
    endfunction

    function void angle_trig(logic signed [14:0] ang, output longint s, output longint c);
        longint u, q, rem;
        longint unsigned s0, c0;
        u = longint'(ang);
        if (u < 0)
            u += 46080;
        q = u / 11520;
        rem = u % 11520;
        if (rem <= 5760)
            octant(rem, s0, c0);
        else
            octant(11520 - rem, c0, s0);
        case (q & 3)
            0: begin s = s0;  c = c0;  end
            1: begin s = c0;  c = -s0; end
            2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
        endcase
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function longint unsigned sq_mag(longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        return m * m;
    endfunction

    function logic [15:0] one_rod(longint sp, longint cp, longint sr, longint cr,
                                  longint y, longint ay);
        longint vy, vz, vx12, vy12, vz12, cx, cz, dx, dy, dz;
        longint unsigned len;
        vy = y * cr - geom[2] * sr;
        vz = y * sr + geom[2] * cr + geom[3] * (longint'(1) << 30);
        vx12 = geom[0] * 4096;
        vy12 = round_half_away(vy, 18);
        vz12 = round_half_away(vz, 18);
        cx = round_half_away(cp * vx12 + sp * vz12, 30);
        cz = round_half_away(cp * vz12 - sp * vx12, 30);
        dx = geom[4] * 4096 - cx;
        dy = ay * 4096 - vy12;
        dz = geom[6] * 4096 - cz;
        len = (floor_sqrt(sq_mag(dx) + sq_mag(dy) + sq_mag(dz)) + 2048) >> 12;
        return (len > 65535) ? 16'hffff : len[15:0];
    endfunction

    function void note_pose(logic signed [14:0] pitch, logic signed [14:0] roll);
        longint sp, cp, sr, cr;
        angle_trig(pitch, sp, cp);
        angle_trig(roll, sr, cr);
        first_q.push_back(one_rod(sp, cp, sr, cr, geom[1], geom[5]));
        second_q.push_back(one_rod(sp, cp, sr, cr, -geom[1], -geom[5]));
    endfunction

    function void check_lengths(logic [15:0] first_len, logic [15:0] second_len);
        logic [15:0] e1, e2;
        n_seen++;
        if (first_q.size() == 0)
        begin
            $error("result with no item outstanding: %0d %0d", first_len, second_len);
            n_fail++;
            return;
        end
        e1 = first_q.pop_front();
        e2 = second_q.pop_front();
        if (e1 !== first_len)
        begin
            $error("first_rod_length expected %0d actual %0d", e1, first_len);
            n_fail++;
        end
        if (e2 !== second_len)
        begin
            $error("second_rod_length expected %0d actual %0d", e2, second_len);
            n_fail++;
        end
    endfunction

    function int pending();
        return first_q.size();
    endfunction
endclass

module tb_ankle_rod_length_kinematics_unit;
    import arlk_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [ANG_W-1:0] pitch_angle;
    logic signed [ANG_W-1:0] roll_angle;
    logic                    out_valid;
    logic                    out_stall;
    logic [LEN_W-1:0]        first_rod_length;
    logic [LEN_W-1:0]        second_rod_length;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    rod_length_scoreboard board;
    int poses_sent;
    int settings_used;
    // receiver stall pattern: mode 0 never stalls, 1 light, 2 heavy, 3 periodic
    int stall_mode;
    int stall_tick;

    ankle_rod_length_kinematics_unit u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .pitch_angle       (pitch_angle),
        .roll_angle        (roll_angle),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .first_rod_length  (first_rod_length),
        .second_rod_length (second_rod_length),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // receiver: check every accepted result at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_lengths(first_rod_length, second_rod_length);
    end

    // receiver stall pattern, changed at the falling edge
    always @(negedge clk)
    begin
        stall_tick++;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) == 0);
            2: out_stall <= ($urandom_range(0, 2) != 0);
            default: out_stall <= (stall_tick % 7) < 3;
        endcase
    end

    // give one item to the block and wait until it is taken
    task automatic send_pose(input logic signed [ANG_W-1:0] pitch,
                             input logic signed [ANG_W-1:0] roll);
        in_valid    <= 1'b1;
        pitch_angle <= pitch;
        roll_angle  <= roll;
        do
            @(posedge clk);
        while (in_stall);
        board.note_pose(pitch, roll);
        poses_sent++;
        @(negedge clk);
    endtask

    task automatic go_quiet(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // random pose: mostly the working range, sometimes any 15 bit pattern
    task automatic send_random_pose();
        logic signed [ANG_W-1:0] p, r;
        if ($urandom_range(0, 3) == 0)
        begin
            p = ANG_W'($urandom());
            r = ANG_W'($urandom());
        end
        else
        begin
            p = ANG_W'(int'($urandom_range(0, 23040)) - 11520);
            r = ANG_W'(int'($urandom_range(0, 23040)) - 11520);
        end
        send_pose(p, r);
    endtask

    // drain the pipe so that a register write finds the block idle
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, data);
    endtask

    // burst of random poses with random gaps
    task automatic random_burst_run(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst) send_random_pose();
            left -= burst;
            if ($urandom_range(0, 2) != 0)
                go_quiet($urandom_range(1, 8));
        end
    endtask

    task automatic write_all(input logic [CFG_W-1:0] v0, input logic [CFG_W-1:0] v1,
                             input logic [CFG_W-1:0] v2, input logic [CFG_W-1:0] v3,
                             input logic [CFG_W-1:0] v4, input logic [CFG_W-1:0] v5,
                             input logic [CFG_W-1:0] v6);
        drain();
        write_reg(REG_ROD_X, v0);
        write_reg(REG_ROD_Y, v1);
        write_reg(REG_ROD_Z, v2);
        write_reg(REG_AXIS_Z, v3);
        write_reg(REG_ANCHOR_X, v4);
        write_reg(REG_ANCHOR_Y, v5);
        write_reg(REG_ANCHOR_Z, v6);
        settings_used++;
    endtask

    initial
    begin
        board = new();
        board.load_defaults();
        board.n_fail = 0;
        board.n_seen = 0;
        poses_sent = 0;
        settings_used = 1;
        stall_mode = 0;
        stall_tick = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pitch_angle = '0;
        roll_angle = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero pose, the range ends, octant and quadrant borders
        send_pose(15'sd0, 15'sd0);
        send_pose(15'sd11520, 15'sd0);
        send_pose(-15'sd11520, 15'sd0);
        send_pose(15'sd0, 15'sd11520);
        send_pose(15'sd0, -15'sd11520);
        send_pose(15'sd5760, -15'sd5760);
        send_pose(15'sd5761, 15'sd5759);
        send_pose(15'sd11520, -15'sd11520);
        // beyond ninety degrees: raw 15 bit extremes
        send_pose(15'sh3fff, 15'sh4000);
        send_pose(15'sh4000, 15'sh3fff);
        send_pose(15'sh7fff, 15'sh0001);
        send_pose(15'sh2d00, 15'sh5a00);
        send_pose(-15'sd1, 15'sd1);
        send_pose(15'sh2aaa, 15'sh5555);
        send_pose(15'sh5555, 15'sh2aaa);

        // overflow: far anchor so the length saturates; index 7 must be ignored
        write_all(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= 3'd7;
        cfg_data <= 16'h1234;
        @(negedge clk);
        cfg_we <= 1'b0;
        send_pose(15'sd0, 15'sd0);
        send_pose(15'sd11520, 15'sd11520);
        send_pose(-15'sd5760, 15'sd3000);
        send_pose(15'sh4000, 15'sh7fff);

        // random part over several settings and stall patterns
        stall_mode = 1;
        write_all(RST_ROD_X, RST_ROD_Y, RST_ROD_Z, RST_AXIS_Z,
                  RST_ANCHOR_X, RST_ANCHOR_Y, RST_ANCHOR_Z);
        random_burst_run(200);
        stall_mode = 2;
        write_all(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
        random_burst_run(80);
        stall_mode = 3;
        write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        random_burst_run(60);
        stall_mode = 0;
        write_all(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
                  CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
                  CFG_W'($urandom()));
        random_burst_run(100);
        stall_mode = 1;
        write_all(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
                  CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
                  CFG_W'($urandom()));
        random_burst_run(100);

        drain();
        stall_mode = 0;
        repeat (20) @(negedge clk);
        $display("%0d poses over %0d register settings, %0d results checked",
                 poses_sent, settings_used, board.n_seen);
        if (board.n_fail == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
